@@ sv/bilinear_texture_sampler_2d_top_assert.svh @@
// Assertion macros shared by the bilinear texture sampler RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef BILINEAR_TEXTURE_SAMPLER_2D_TOP_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_2D_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_CHECK_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTS_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/bts_pkg.sv @@
// Shared types, codes and helper functions for the bilinear texture sampler.
// No dependencies; used by bts_fetch and the top level.
`default_nettype none

package bts_pkg;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] WRAP_REPEAT = 2'd0;
  localparam logic [1:0] WRAP_CLAMP  = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;
  localparam logic [1:0] WRAP_BORDER = 2'd3;

  localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WRAP_S     = 3'd2;
  localparam logic [2:0] REG_WRAP_T     = 3'd3;
  localparam logic [2:0] REG_LINEAR     = 3'd4;
  localparam logic [2:0] REG_HERMITE    = 3'd5;
  localparam logic [2:0] REG_BORDER     = 3'd6;

  // Where a fetched texel comes from.
  localparam logic [1:0] SRC_MEM    = 2'd0;
  localparam logic [1:0] SRC_BORDER = 2'd1;
  localparam logic [1:0] SRC_ZERO   = 2'd2;

  typedef struct packed {
    logic       neg;
    logic       lo0;
    logic       hi0;
    logic       lo1;
    logic       hi1;
    logic [7:0] fl8;
  } axis_flags_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic       b0;
    logic       b1;
  } wrap_res_t;

  typedef struct packed {
    logic             cmd;
    logic [15:0]      index;
    logic [31:0]      value;
    logic [3:0][15:0] addr;
    logic [3:0]       brd;
    logic [7:0]       wa;
    logic [7:0]       wb;
    logic             lin;
  } fetch_req_t;

  typedef struct packed {
    logic [3:0][31:0] tex;
    logic [7:0]       wa;
    logic [7:0]       wb;
    logic             lin;
  } tex_grp_t;

  function automatic logic [8:0] eff_size(input logic [8:0] r);
    logic [8:0] s;
    if (r == 9'd0) begin
      s = 9'd1;
    end else if (r > 9'd256) begin
      s = 9'd256;
    end else begin
      s = r;
    end
    return s;
  endfunction

  // Turns the remainder and range flags of one axis into the two wrapped
  // texel positions and their border marks.
  function automatic wrap_res_t wrap_pair(input logic [9:0] r, input axis_flags_t fl,
                                          input logic [8:0] size, input logic [1:0] mode);
    logic [9:0] sz;
    logic [9:0] m_mod;
    logic [9:0] m0;
    logic [9:0] m1;
    logic [9:0] mir0;
    logic [9:0] mir1;
    wrap_res_t  res;
    sz    = {1'b0, size};
    m_mod = (mode == WRAP_MIRROR) ? {size, 1'b0} : sz;
    m0    = (fl.neg && r != 10'd0) ? m_mod - r : r;
    m1    = (m0 + 10'd1 == m_mod) ? 10'd0 : m0 + 10'd1;
    mir0  = (m0 < sz) ? m0 : m_mod - 10'd1 - m0;
    mir1  = (m1 < sz) ? m1 : m_mod - 10'd1 - m1;
    res   = '0;
    case (mode)
      WRAP_REPEAT: begin
        res.c0 = m0[7:0];
        res.c1 = m1[7:0];
      end
      WRAP_MIRROR: begin
        res.c0 = mir0[7:0];
        res.c1 = mir1[7:0];
      end
      WRAP_CLAMP: begin
        res.c0 = fl.lo0 ? 8'd0 : (fl.hi0 ? 8'(sz - 10'd1) : fl.fl8);
        res.c1 = fl.lo1 ? 8'd0 : (fl.hi1 ? 8'(sz - 10'd1) : fl.fl8 + 8'd1);
      end
      default: begin
        res.c0 = fl.fl8;
        res.c1 = fl.fl8 + 8'd1;
        res.b0 = fl.lo0 | fl.hi0;
        res.b1 = fl.lo1 | fl.hi1;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/bts_fetch.sv @@
// Texel memory with its single-port access sequencer and read gather stage.
// Depends on bts_pkg and the assertion macro header.
`default_nettype none
`include "bilinear_texture_sampler_2d_top_assert.svh"

module bts_fetch #(
  parameter int TEXEL_DEPTH = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         border_rgba,
  input  logic                req_valid,
  output logic                req_ready,
  input  bts_pkg::fetch_req_t req,
  output logic                grp_valid,
  input  logic                grp_ready,
  output bts_pkg::tex_grp_t   grp
);
  import bts_pkg::*;

  localparam int AW = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam logic [24:0] DEPTH_LIM = 25'(TEXEL_DEPTH);

  logic [31:0] mem [TEXEL_DEPTH];
  logic [31:0] rdata;

  fetch_req_t  f;
  logic        f_v;
  logic [1:0]  k;

  logic        r_valid;
  logic [1:0]  r_slot;
  logic        r_last;
  logic [1:0]  r_kind;
  logic [7:0]  r_wa;
  logic [7:0]  r_wb;
  logic        r_lin;
  logic [2:0][31:0] slot;

  logic        stall_r;
  logic        go;
  logic        issue_last;
  logic        mem_we;
  logic        mem_re;
  logic [15:0] rd_addr;
  logic        rd_ok;
  logic        wr_ok;
  logic [31:0] resolved;

  // The gather stage holds its last texel while the blend side is full;
  // nothing new may be read until it has gone.
  assign stall_r    = r_valid && r_last && !grp_ready;
  assign go         = f_v && !stall_r;
  assign issue_last = (f.cmd == CMD_WRITE) || (k == (f.lin ? 2'd3 : 2'd0));
  assign req_ready  = !f_v || (go && issue_last);

  assign rd_addr = f.addr[k];
  assign rd_ok   = {9'd0, rd_addr} < DEPTH_LIM;
  assign wr_ok   = {9'd0, f.index} < DEPTH_LIM;
  assign mem_we  = go && (f.cmd == CMD_WRITE) && wr_ok;
  assign mem_re  = go && (f.cmd == CMD_SAMPLE) && !f.brd[k] && rd_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'({8'd0, f.index})] <= f.value;
    end
    if (mem_re) begin
      rdata <= mem[AW'({8'd0, rd_addr})];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
      k   <= 2'd0;
    end else if (req_ready) begin
      f_v <= req_valid;
      k   <= 2'd0;
    end else if (go) begin
      k   <= k + 2'd1;
    end
    if (req_ready) begin
      f <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!stall_r) begin
      r_valid <= go && (f.cmd == CMD_SAMPLE);
    end
    if (!stall_r) begin
      r_slot <= k;
      r_last <= issue_last;
      r_wa   <= f.wa;
      r_wb   <= f.wb;
      r_lin  <= f.lin;
      if (f.brd[k]) begin
        r_kind <= SRC_BORDER;
      end else if (rd_ok) begin
        r_kind <= SRC_MEM;
      end else begin
        r_kind <= SRC_ZERO;
      end
    end
    if (r_valid && !r_last) begin
      slot[r_slot] <= resolved;
    end
  end

  always_comb begin
    case (r_kind)
      SRC_MEM:    resolved = rdata;
      SRC_BORDER: resolved = border_rgba;
      default:    resolved = 32'd0;
    endcase
  end

  // Nearest sampling only uses the first slot; the rest are zeroed.
  always_comb begin
    grp = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) == r_slot) begin
        grp.tex[i] = resolved;
      end else if (r_lin && i < 3) begin
        grp.tex[i] = slot[i];
      end
    end
    grp.wa  = r_wa;
    grp.wb  = r_wb;
    grp.lin = r_lin;
  end

  assign grp_valid = r_valid && r_last;

  `BTS_CHECK_NOW(a_one_port, mem_we, !mem_re, "texel memory read and write in one cycle")
  `BTS_CHECK_NEXT(a_hold_rdata, stall_r, $stable(rdata), "held texel changed during stall")
  `BTS_CHECK_NEXT(a_read_tag, mem_re, r_valid, "texel read issued without gather tag")

endmodule

`default_nettype wire

@@ sv/bilinear_texture_sampler_2d_top.sv @@
// Top level of the 2D bilinear texture sampler: registers, coordinate pipeline and blend.
// Depends on bts_pkg, bts_fetch and the assertion macro header.
`default_nettype none
`include "bilinear_texture_sampler_2d_top_assert.svh"

//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------
//  config    | cfg_we              | cfg_index, cfg_data (plain register write)
//  input     | in_valid / in_ready | cmd, texel_index, texel_value, coord_s/t
//  output    | out_valid/out_ready | red_out, green_out, blue_out, alpha_out
//
// A bilinear sample's four texels go through the single texel memory port one per
// cycle while the gather stage is not stalled; a texel write or a nearest sample
// takes the port once. The coordinate and blend pipelines take a new item every
// cycle unless a stall at the fetch or at the output holds them.
// Reset clears the pipeline valid bits and the registers to width 1, height 1
// and zero elsewhere; the texel memory is not cleared and needs no clearing pass.
// A stall on the output backs up stage by stage; no transfer is lost or repeated.

module bilinear_texture_sampler_2d_top #(
  parameter int TEXEL_DEPTH     = 65536,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [15:0]        texel_index,
  input  logic [31:0]        texel_value,
  input  logic signed [31:0] coord_s,
  input  logic signed [31:0] coord_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        red_out,
  output logic [15:0]        green_out,
  output logic [15:0]        blue_out,
  output logic [15:0]        alpha_out
);
  import bts_pkg::*;

  // Scaled coordinate width, integer part width and remainder-unit geometry.
  localparam int XW = 42;
  localparam int IW = XW - COORD_FRAC_BITS;
  localparam int ND = (IW + 3) / 4;
  localparam int DW = ND * 4;
  localparam int NS = ND + 6;
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_FLR  = 2;
  localparam int ST_PREP = 3;
  localparam int ST_WRAP = ND + 4;
  localparam int ST_ADDR = ND + 5;
  localparam logic [XW-1:0] HALF = {{(XW-1){1'b0}}, 1'b1} << (COORD_FRAC_BITS - 1);

  typedef struct packed {
    logic                 cmd;
    logic [15:0]          index;
    logic [31:0]          value;
    logic signed [31:0]   cs;
    logic signed [31:0]   ct;
    logic                 lin;
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] py;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [IW-1:0] fx;
    logic signed [IW-1:0] fy;
    logic [7:0]           wa;
    logic [7:0]           wb;
    logic [15:0]          aax;
    logic [15:0]          aay;
    axis_flags_t          flx;
    axis_flags_t          fly;
    logic [DW-1:0]        qx;
    logic [DW-1:0]        qy;
    logic [9:0]           rx;
    logic [9:0]           ry;
    wrap_res_t            wx;
    wrap_res_t            wy;
    logic [3:0][15:0]     addr;
    logic [3:0]           brd;
  } item_t;

  // Configuration registers.
  logic [8:0]  tex_width;
  logic [8:0]  tex_height;
  logic [1:0]  wrap_mode_s;
  logic [1:0]  wrap_mode_t;
  logic        linear_filter;
  logic        hermite_enable;
  logic [31:0] border_rgba;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width      <= 9'd1;
      tex_height     <= 9'd1;
      wrap_mode_s    <= WRAP_REPEAT;
      wrap_mode_t    <= WRAP_REPEAT;
      linear_filter  <= 1'b0;
      hermite_enable <= 1'b0;
      border_rgba    <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width      <= cfg_data[8:0];
        REG_TEX_HEIGHT: tex_height     <= cfg_data[8:0];
        REG_WRAP_S:     wrap_mode_s    <= cfg_data[1:0];
        REG_WRAP_T:     wrap_mode_t    <= cfg_data[1:0];
        REG_LINEAR:     linear_filter  <= cfg_data[0];
        REG_HERMITE:    hermite_enable <= cfg_data[0];
        REG_BORDER:     border_rgba    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes are clamped to 1..256; the remainder unit works modulo the size,
  // or twice the size for mirrored repeat.
  logic [8:0] w_eff;
  logic [8:0] h_eff;
  logic [9:0] mod_x;
  logic [9:0] mod_y;

  assign w_eff = eff_size(tex_width);
  assign h_eff = eff_size(tex_height);
  assign mod_x = (wrap_mode_s == WRAP_MIRROR) ? {w_eff, 1'b0} : {1'b0, w_eff};
  assign mod_y = (wrap_mode_t == WRAP_MIRROR) ? {h_eff, 1'b0} : {1'b0, h_eff};

  // Coordinate pipeline: input, scale, floor, prepare, ND remainder stages,
  // wrap, address. Each stage moves when it is empty or the next one moves.
  logic  pv   [NS];
  item_t pd   [NS];
  wire   item_t nx [NS];
  logic  prdy [NS];
  logic  req_ready;

  always_comb begin
    prdy[NS-1] = !pv[NS-1] || req_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      prdy[i] = !pv[i] || prdy[i+1];
    end
  end

  assign in_ready = prdy[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rst) begin
        pv[i] <= 1'b0;
      end else if (prdy[i]) begin
        pv[i] <= (i == 0) ? in_valid : pv[(i == 0) ? 0 : i - 1];
      end
      if (prdy[i]) begin
        pd[i] <= nx[i];
      end
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    item_t n;
    assign nx[g] = n;

    if (g == ST_IN) begin : g_in
      always_comb begin
        n       = '0;
        n.cmd   = cmd;
        n.index = texel_index;
        n.value = texel_value;
        n.cs    = coord_s;
        n.ct    = coord_t;
        n.lin   = linear_filter;
      end
    end else if (g == ST_MUL) begin : g_mul
      // X = s*size - ceil(s / 2^F); the ceiling is -floor(-s / 2^F).
      logic signed [32:0] ns;
      logic signed [32:0] nt;
      always_comb begin
        n    = pd[g-1];
        ns   = -$signed({pd[g-1].cs[31], pd[g-1].cs});
        nt   = -$signed({pd[g-1].ct[31], pd[g-1].ct});
        n.px = pd[g-1].cs * $signed({1'b0, w_eff});
        n.py = pd[g-1].ct * $signed({1'b0, h_eff});
        n.cx = XW'(ns >>> COORD_FRAC_BITS);
        n.cy = XW'(nt >>> COORD_FRAC_BITS);
      end
    end else if (g == ST_FLR) begin : g_flr
      // Bilinear sampling moves back by half a texel before the floor.
      logic signed [XW-1:0] ux;
      logic signed [XW-1:0] uy;
      always_comb begin
        n    = pd[g-1];
        ux   = pd[g-1].px + pd[g-1].cx - (pd[g-1].lin ? HALF : '0);
        uy   = pd[g-1].py + pd[g-1].cy - (pd[g-1].lin ? HALF : '0);
        n.fx = ux[XW-1:COORD_FRAC_BITS];
        n.fy = uy[XW-1:COORD_FRAC_BITS];
        n.wa = pd[g-1].lin ? ux[COORD_FRAC_BITS-1 -: 8] : 8'd0;
        n.wb = pd[g-1].lin ? uy[COORD_FRAC_BITS-1 -: 8] : 8'd0;
      end
    end else if (g == ST_PREP) begin : g_prep
      logic [IW-1:0] magx;
      logic [IW-1:0] magy;
      always_comb begin
        n          = pd[g-1];
        magx       = pd[g-1].fx[IW-1] ? IW'(-pd[g-1].fx) : IW'(pd[g-1].fx);
        magy       = pd[g-1].fy[IW-1] ? IW'(-pd[g-1].fy) : IW'(pd[g-1].fy);
        n.qx       = DW'(magx);
        n.qy       = DW'(magy);
        n.rx       = 10'd0;
        n.ry       = 10'd0;
        n.aax      = pd[g-1].wa * pd[g-1].wa;
        n.aay      = pd[g-1].wb * pd[g-1].wb;
        n.flx.neg  = pd[g-1].fx[IW-1];
        n.flx.lo0  = pd[g-1].fx[IW-1];
        n.flx.lo1  = pd[g-1].fx[IW-1] && !(&pd[g-1].fx);
        n.flx.hi0  = !pd[g-1].fx[IW-1] && (IW'(pd[g-1].fx) >= IW'(w_eff));
        n.flx.hi1  = !pd[g-1].fx[IW-1] && (IW'(pd[g-1].fx) >= IW'(w_eff) - IW'(1));
        n.flx.fl8  = pd[g-1].fx[7:0];
        n.fly.neg  = pd[g-1].fy[IW-1];
        n.fly.lo0  = pd[g-1].fy[IW-1];
        n.fly.lo1  = pd[g-1].fy[IW-1] && !(&pd[g-1].fy);
        n.fly.hi0  = !pd[g-1].fy[IW-1] && (IW'(pd[g-1].fy) >= IW'(h_eff));
        n.fly.hi1  = !pd[g-1].fy[IW-1] && (IW'(pd[g-1].fy) >= IW'(h_eff) - IW'(1));
        n.fly.fl8  = pd[g-1].fy[7:0];
      end
    end else if (g < ST_WRAP) begin : g_div
      // Four restoring remainder steps per stage, most significant bit first.
      logic [DW-1:0] qx;
      logic [DW-1:0] qy;
      logic [9:0]    rx;
      logic [9:0]    ry;
      always_comb begin
        n  = pd[g-1];
        qx = pd[g-1].qx;
        qy = pd[g-1].qy;
        rx = pd[g-1].rx;
        ry = pd[g-1].ry;
        for (int b = 0; b < 4; b++) begin
          rx = {rx[8:0], qx[DW-1]};
          ry = {ry[8:0], qy[DW-1]};
          qx = qx << 1;
          qy = qy << 1;
          if (rx >= mod_x) begin
            rx = rx - mod_x;
          end
          if (ry >= mod_y) begin
            ry = ry - mod_y;
          end
        end
        n.qx = qx;
        n.qy = qy;
        n.rx = rx;
        n.ry = ry;
      end
    end else if (g == ST_WRAP) begin : g_wrap
      logic [25:0] hx;
      logic [25:0] hy;
      always_comb begin
        n    = pd[g-1];
        n.wx = wrap_pair(pd[g-1].rx, pd[g-1].flx, w_eff, wrap_mode_s);
        n.wy = wrap_pair(pd[g-1].ry, pd[g-1].fly, h_eff, wrap_mode_t);
        // Smoothstep weight a*a*(3 - 2a) in 8-bit fixed point.
        hx   = pd[g-1].aax * (10'd768 - {1'b0, pd[g-1].wa, 1'b0});
        hy   = pd[g-1].aay * (10'd768 - {1'b0, pd[g-1].wb, 1'b0});
        n.wa = hermite_enable ? hx[23:16] : pd[g-1].wa;
        n.wb = hermite_enable ? hy[23:16] : pd[g-1].wb;
      end
    end else begin : g_addr
      // Slot order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
      logic [16:0] row0;
      logic [16:0] row1;
      always_comb begin
        n         = pd[g-1];
        row0      = pd[g-1].wy.c0 * w_eff;
        row1      = pd[g-1].wy.c1 * w_eff;
        n.addr[0] = 16'(row0 + {9'd0, pd[g-1].wx.c0});
        n.addr[1] = 16'(row0 + {9'd0, pd[g-1].wx.c1});
        n.addr[2] = 16'(row1 + {9'd0, pd[g-1].wx.c0});
        n.addr[3] = 16'(row1 + {9'd0, pd[g-1].wx.c1});
        n.brd[0]  = pd[g-1].wx.b0 | pd[g-1].wy.b0;
        n.brd[1]  = pd[g-1].wx.b1 | pd[g-1].wy.b0;
        n.brd[2]  = pd[g-1].wx.b0 | pd[g-1].wy.b1;
        n.brd[3]  = pd[g-1].wx.b1 | pd[g-1].wy.b1;
      end
    end
  end

  fetch_req_t req;
  tex_grp_t   grp;
  logic       grp_valid;
  logic       b1_rdy;

  always_comb begin
    req       = '0;
    req.cmd   = pd[NS-1].cmd;
    req.index = pd[NS-1].index;
    req.value = pd[NS-1].value;
    req.addr  = pd[NS-1].addr;
    req.brd   = pd[NS-1].brd;
    req.wa    = pd[NS-1].wa;
    req.wb    = pd[NS-1].wb;
    req.lin   = pd[NS-1].lin;
  end

  bts_fetch #(
    .TEXEL_DEPTH(TEXEL_DEPTH)
  ) u_fetch (
    .clk         (clk),
    .rst         (rst),
    .border_rgba (border_rgba),
    .req_valid   (pv[NS-1]),
    .req_ready   (req_ready),
    .req         (req),
    .grp_valid   (grp_valid),
    .grp_ready   (b1_rdy),
    .grp         (grp)
  );

  // Blend pipeline: texel group, corner weights, per-channel products, sum.
  tex_grp_t          b1;
  logic              b1_v;
  logic [3:0][31:0]  b2_tex;
  logic [3:0][16:0]  b2_w;
  logic              b2_v;
  logic [3:0][3:0][24:0] b3_p;
  logic              b3_v;
  logic [3:0][15:0]  b4_c;
  logic              b4_v;
  logic              b2_rdy;
  logic              b3_rdy;
  logic              b4_rdy;
  logic [8:0]        ia;
  logic [8:0]        ib;
  logic [26:0]       acc [4];

  assign b4_rdy = !b4_v || out_ready;
  assign b3_rdy = !b3_v || b4_rdy;
  assign b2_rdy = !b2_v || b3_rdy;
  assign b1_rdy = !b1_v || b2_rdy;

  assign ia = 9'd256 - {1'b0, b1.wa};
  assign ib = 9'd256 - {1'b0, b1.wb};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = 27'(b3_p[c][0]) + 27'(b3_p[c][1]) + 27'(b3_p[c][2]) + 27'(b3_p[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
    end else begin
      if (b1_rdy) begin
        b1_v <= grp_valid;
      end
      if (b2_rdy) begin
        b2_v <= b1_v;
      end
      if (b3_rdy) begin
        b3_v <= b2_v;
      end
      if (b4_rdy) begin
        b4_v <= b3_v;
      end
    end
    if (b1_rdy) begin
      b1 <= grp;
    end
    if (b2_rdy) begin
      b2_tex  <= b1.tex;
      b2_w[0] <= 17'(ia * ib);
      b2_w[1] <= 17'({1'b0, b1.wa} * ib);
      b2_w[2] <= 17'(ia * {1'b0, b1.wb});
      b2_w[3] <= 17'({1'b0, b1.wa} * {1'b0, b1.wb});
    end
    if (b3_rdy) begin
      for (int c = 0; c < 4; c++) begin
        for (int s = 0; s < 4; s++) begin
          b3_p[c][s] <= b2_tex[s][8*c +: 8] * b2_w[s];
        end
      end
    end
    if (b4_rdy) begin
      for (int c = 0; c < 4; c++) begin
        b4_c[c] <= acc[c][23:8];
      end
    end
  end

  assign out_valid = b4_v;
  assign red_out   = b4_c[0];
  assign green_out = b4_c[1];
  assign blue_out  = b4_c[2];
  assign alpha_out = b4_c[3];

  `BTS_CHECK_NEXT(a_in_load, in_valid && in_ready, pv[0], "accepted input not captured")
  `BTS_CHECK_NEXT(a_stage_hold, pv[0] && !prdy[1], pv[0] && $stable(pd[0]), "input stage lost item")
  `BTS_CHECK_NOW(a_near_wt, b1_v && !b1.lin, b1.wa == 8'd0 && b1.wb == 8'd0, "nearest weight set")

endmodule

`default_nettype wire
